FILE: hw/rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
// Holds the transaction structs, status and command codes, and the cell interface structs.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

	localparam int KEY_W   = 64;
	localparam int VALUE_W = 32;
	localparam int SLOT_W  = 4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic               command;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] payload;
	} skt_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] found_value;
	} skt_rsp_t;

	typedef struct packed {
		logic               write_en;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} skt_bcast_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic le;
		logic move;
		logic take_new;
	} skt_flags_t;

endpackage

FILE: hw/rtl/skt_cell.sv
// One cell of the sorted key table: a key/value register pair with its compare logic.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell (
	input  logic                    clk,
	input  skt_pkg::skt_bcast_t     bcast,
	input  logic                    cell_valid,
	input  logic                    first_cell,
	input  skt_pkg::skt_flags_t     left_flags,
	input  logic [skt_pkg::KEY_W-1:0]   left_key,
	input  logic [skt_pkg::VALUE_W-1:0] left_value,
	output logic [skt_pkg::KEY_W-1:0]   key,
	output logic [skt_pkg::VALUE_W-1:0] value,
	output skt_pkg::skt_flags_t     flags
);
	import skt_pkg::*;

	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic               gt;

	assign gt = key_q > bcast.key;

	always_comb begin
		flags.lt       = key_q < bcast.key;
		flags.eq       = key_q == bcast.key;
		flags.le       = cell_valid && !gt;
		flags.move     = cell_valid && gt;
		flags.take_new = (!cell_valid || gt) && (first_cell || left_flags.le);
	end

	always_ff @(posedge clk) begin
		if (bcast.write_en) begin
			if (left_flags.move) begin
				key_q   <= left_key;
				value_q <= left_value;
			end else if (flags.take_new) begin
				key_q   <= bcast.key;
				value_q <= bcast.value;
			end
		end
	end

	assign key   = key_q;
	assign value = value_q;

endmodule

FILE: hw/rtl/sorted_key_table_core.sv
// Top level of the sorted key table: request control, row of cells and search sequencer.
// Depends on skt_pkg and skt_cell.
//
//   Channel    Handshake          Payload
//   request    start / busy       request  (skt_req_t)
//   response   done strobe        response (skt_rsp_t)
//
// An insert runs as a single step: every cell shifts or loads in parallel.
// A lookup is a binary search, one search probe per cycle through the compare flags
// of the cell selected by the midpoint index.
// The response strobe rises at the same edge that drops busy, so it is high in the first
// cycle with busy low, and it cannot be stalled.
// Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_key_table_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  skt_pkg::skt_req_t request,
	output logic              done,
	output skt_pkg::skt_rsp_t response
);
	import skt_pkg::*;

	localparam int CntW = $clog2(MAX_ENTRIES + 1);
	localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PadW = IdxW + SLOT_W;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_INSERT = 3'b010,
		S_SEARCH = 3'b100
	} state_t;

	state_t            state_q;
	skt_req_t          req_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   low_q;
	logic [CntW-1:0]   high_q;
	logic              done_q;
	skt_rsp_t          rsp_q;

	skt_bcast_t        bcast;
	logic              full;
	logic [KEY_W-1:0]  cell_key   [MAX_ENTRIES];
	logic [VALUE_W-1:0] cell_value [MAX_ENTRIES];
	skt_flags_t        cell_flags [MAX_ENTRIES];

	logic [IdxW-1:0]   pos;
	logic [PadW-1:0]   pos_wide;
	logic [CntW-1:0]   mid;
	logic [IdxW-1:0]   mid_idx;
	logic [PadW-1:0]   mid_wide;

	assign full           = count_q == CntW'(MAX_ENTRIES);
	assign bcast.write_en = (state_q == S_INSERT) && !full;
	assign bcast.key      = req_q.key;
	assign bcast.value    = req_q.payload;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		skt_flags_t         lf;
		logic [KEY_W-1:0]   lk;
		logic [VALUE_W-1:0] lv;

		if (i == 0) begin : g_first
			assign lf = '{lt: 1'b0, eq: 1'b0, le: 1'b1, move: 1'b0, take_new: 1'b0};
			assign lk = '0;
			assign lv = '0;
		end else begin : g_rest
			assign lf = cell_flags[i-1];
			assign lk = cell_key[i-1];
			assign lv = cell_value[i-1];
		end

		skt_cell u_cell (
			.clk        (clk),
			.bcast      (bcast),
			.cell_valid (count_q > CntW'(i)),
			.first_cell (i == 0),
			.left_flags (lf),
			.left_key   (lk),
			.left_value (lv),
			.key        (cell_key[i]),
			.value      (cell_value[i]),
			.flags      (cell_flags[i])
		);
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (cell_flags[i].take_new) begin
				pos = pos | IdxW'(i);
			end
		end
	end

	assign pos_wide = PadW'(pos);
	assign mid      = low_q + ((high_q - low_q) >> 1);
	assign mid_idx  = mid[IdxW-1:0];
	assign mid_wide = PadW'(mid_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (request.command == CMD_LOOKUP) ? S_SEARCH : S_INSERT;
					end
				end
				S_INSERT: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SEARCH: begin
					if (low_q >= high_q || cell_flags[mid_idx].eq) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q  <= request;
					low_q  <= '0;
					high_q <= count_q;
				end
			end
			S_INSERT: begin
				if (full) begin
					rsp_q <= '{status: STATUS_FULL, slot: '0, found_value: '0};
				end else begin
					rsp_q <= '{status: STATUS_OK, slot: pos_wide[SLOT_W-1:0], found_value: '0};
				end
			end
			S_SEARCH: begin
				if (low_q >= high_q) begin
					rsp_q <= '{status: STATUS_NOT_FOUND, slot: '0, found_value: '0};
				end else if (cell_flags[mid_idx].eq) begin
					rsp_q <= '{status: STATUS_OK, slot: mid_wide[SLOT_W-1:0],
						found_value: cell_value[mid_idx]};
				end else if (cell_flags[mid_idx].lt) begin
					low_q <= mid + 1'b1;
				end else begin
					high_q <= mid;
				end
			end
			default: ;
		endcase
	end

	assign busy     = state_q != S_IDLE;
	assign done     = done_q;
	assign response = rsp_q;

endmodule

FILE: hw/rtl/skt_checker.sv
// Port-level checker for the sorted key table and its bind to the top level.
// Depends on skt_pkg and sorted_key_table_core.
`timescale 1ns / 1ps

module skt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input skt_pkg::skt_req_t request,
	input logic              done,
	input skt_pkg::skt_rsp_t response
);
	import skt_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results back to back");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (response.status == STATUS_OK || response.status == STATUS_NOT_FOUND ||
			response.status == STATUS_FULL))
		else $error("undefined status code");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && response.status != STATUS_OK |-> response.slot == '0 &&
			response.found_value == '0)
		else $error("failed transaction carries nonzero slot or value");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (.*);
